// ===== hdl/alm_pkg.sv =====
// ----------------------------------------------------------------------------
// alm_pkg: shared types and constants
// Commands, status codes, register indexes and sequencer states for the
// arc length table block.
// ----------------------------------------------------------------------------
package alm_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_MISMATCH = 2'd2
  } status_t;

  localparam logic [1:0] REG_RESOLUTION   = 2'd0;
  localparam logic [1:0] REG_LAST_SEGMENT = 2'd1;

  localparam logic [31:0] MIN_RES     = 32'd66;
  localparam logic [31:0] SMALL_REST  = 32'd656;
  localparam logic [31:0] RES_RESET   = 32'd6554;
  localparam logic [23:0] POS_MASK    = 24'hFFFFFF;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_DIST_SQ,
    ST_DIST_GO,
    ST_DIST_WAIT,
    ST_SAMPLE_ADD,
    ST_APP_CHECK,
    ST_APP_MUL,
    ST_APP_DIV,
    ST_APP_WAIT,
    ST_SAMPLE_END,
    ST_FIN_GO,
    ST_FIN_WAIT,
    ST_FIN_DECIDE,
    ST_FIN_READ,
    ST_FIN_MUL,
    ST_FIN_DIV,
    ST_FIN_WAIT2,
    ST_FIN_STATUS,
    ST_Q_CHECK,
    ST_Q_WAIT,
    ST_Q_FRAC,
    ST_Q_FWAIT,
    ST_Q_RD0,
    ST_Q_RD1,
    ST_Q_MIX,
    ST_Q_OUT,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/arc_length_table_build_and_map_core.sv =====
// ----------------------------------------------------------------------------
// arc_length_table_build_and_map_core: arc length table build and map
// Builds a distance-to-curve-position table from sampled points and maps
// distances back to segment and blend through it.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake               Payload
// in        in   in_valid / in_ready     command, point_x/y/z, curve_position,
//                                        query_distance
// out       out  out_valid / out_ready   segment, blend, curve_length, status
// cfg       in   cfg_write               cfg_index, cfg_data
//
// One item at a time. Start: a table write and a reset of the build state.
// Sample: the distance (3 squaring steps, then the root) plus a multiply and
// a divide per table entry appended. Finish: a divide, then at most a table
// read, a multiply and a divide for the closing entry. Query: two divides and
// up to two table reads. The divider is shared by sample, finish and query.
// Reset is synchronous and clears all control state; the table needs none.
// in_ready is high in idle even while a result waits on a stalled out port.
//
module arc_length_table_build_and_map_core
  import alm_pkg::*;
#(
  parameter int TABLE_DEPTH  = 1024,
  parameter int SEGMENT_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              command,
  input  logic signed [31:0]      point_x,
  input  logic signed [31:0]      point_y,
  input  logic signed [31:0]      point_z,
  input  logic [23:0]             curve_position,
  input  logic signed [31:0]      query_distance,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SEGMENT_BITS-1:0] segment,
  output logic [16:0]             blend,
  output logic [31:0]             curve_length,
  output logic [1:0]              status,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t state, state_next;

  // configuration
  logic [31:0] resolution;
  logic [7:0]  last_segment;
  logic [31:0] res;

  // captured item
  logic signed [31:0] px, py, pz;
  logic [23:0]        next_pos;
  logic [31:0]        qdist;

  // build state
  logic [CW-1:0]      entry_count;
  logic [31:0]        pending;
  logic [23:0]        last_pos;
  logic signed [31:0] prev_x, prev_y, prev_z;
  logic [31:0]        total;
  logic               ovf;

  // working registers
  logic [1:0]  sq_idx;
  logic [65:0] sq_sum;
  logic [31:0] step_len;
  logic [56:0] prod;
  logic        dir_up;
  logic [33:0] fq;
  logic [23:0] t0;
  logic [CW-1:0] idx;
  logic [15:0] frac;

  logic [SEGMENT_BITS-1:0] r_seg;
  logic [16:0]             r_blend;
  status_t                 r_status;

  // unit hookups
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [23:0]   mem_wdata, mem_rdata;
  logic          div_start, div_done;
  logic [63:0]   div_dividend, div_quot;
  logic [31:0]   div_divisor, div_rem;
  logic          sqrt_start, sqrt_done;
  logic [31:0]   sqrt_root;

  // datapath helpers
  logic signed [31:0] cur_p, cur_prev;
  logic signed [32:0] dcomp;
  logic [32:0]        dmag;
  logic [63:0]        sq_prod;
  logic [32:0]        tsum, psum;
  logic [23:0]        app_new;
  logic [23:0]        app_diff;
  logic [55:0]        app_prod;
  logic [24:0]        end_pos;
  logic [24:0]        fin_rem;
  logic [56:0]        fin_prod;
  logic [64:0]        fin_w;
  logic [23:0]        fin_v;
  logic [CW-1:0]      count_m1;
  logic [23:0]        mix_diff;
  logic [39:0]        mix_prod;
  logic [23:0]        q_v;

  assign res      = (resolution < MIN_RES) ? MIN_RES : resolution;
  assign count_m1 = entry_count - CW'(1);
  assign end_pos  = {17'd0, last_segment} + 25'd1 << 16;

  always_comb begin
    case (sq_idx)
      2'd0:    begin cur_p = px; cur_prev = prev_x; end
      2'd1:    begin cur_p = py; cur_prev = prev_y; end
      default: begin cur_p = pz; cur_prev = prev_z; end
    endcase
  end
  assign dcomp = 33'(cur_p) - 33'(cur_prev);
  assign dmag  = dcomp[32] ? 33'(-dcomp) : 33'(dcomp);
  // component difference is below 2^32, so the low 32 bits carry it
  assign sq_prod = 64'(dmag[31:0]) * 64'(dmag[31:0]);

  assign tsum = {1'b0, total} + {1'b0, step_len};
  assign psum = {1'b0, pending} + {1'b0, step_len};

  // appended position, truncated toward the last position
  assign app_new = dir_up ? 24'(last_pos + div_quot[23:0])
                          : 24'(last_pos - div_quot[23:0]);
  assign app_diff = (next_pos >= last_pos) ? 24'(next_pos - last_pos)
                                           : 24'(last_pos - next_pos);
  assign app_prod = 56'(app_diff) * 56'(res);

  assign fin_rem  = (end_pos > {1'b0, t0}) ? 25'(end_pos - {1'b0, t0}) : 25'd0;
  assign fin_prod = 57'(fin_rem) * 57'(res);
  assign fin_w    = {41'd0, t0} + {1'b0, div_quot};
  assign fin_v    = (fin_w > {41'd0, POS_MASK}) ? POS_MASK : fin_w[23:0];

  assign mix_diff = (mem_rdata >= t0) ? 24'(mem_rdata - t0) : 24'(t0 - mem_rdata);
  assign mix_prod = 40'(mix_diff) * 40'(frac);
  assign q_v      = dir_up ? 24'(t0 + prod[39:16]) : 24'(t0 - prod[39:16]);

  assign in_ready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(command))
            CMD_START:  state_next = ST_START;
            CMD_SAMPLE: state_next = ST_DIST_SQ;
            CMD_FINISH: state_next = ST_FIN_GO;
            default:    state_next = ST_Q_CHECK;
          endcase
        end
      end
      ST_START:      state_next = ST_DONE;
      ST_DIST_SQ:    if (sq_idx == 2'd2) state_next = ST_DIST_GO;
      ST_DIST_GO:    state_next = (sq_sum[65:64] != 2'b00) ? ST_SAMPLE_ADD : ST_DIST_WAIT;
      ST_DIST_WAIT:  if (sqrt_done) state_next = ST_SAMPLE_ADD;
      ST_SAMPLE_ADD: state_next = ST_APP_CHECK;
      ST_APP_CHECK: begin
        if (!ovf && pending >= res && entry_count < DEPTH_C) state_next = ST_APP_MUL;
        else state_next = ST_SAMPLE_END;
      end
      ST_APP_MUL:    state_next = ST_APP_DIV;
      ST_APP_DIV:    state_next = ST_APP_WAIT;
      ST_APP_WAIT:   if (div_done) state_next = ST_APP_CHECK;
      ST_SAMPLE_END: state_next = ST_DONE;
      ST_FIN_GO:     state_next = ST_FIN_WAIT;
      ST_FIN_WAIT:   if (div_done) state_next = ST_FIN_DECIDE;
      ST_FIN_DECIDE: begin
        if (ovf || fq == '0) state_next = ST_DONE;
        else if (34'(entry_count) == fq) begin
          if (entry_count >= DEPTH_C) state_next = ST_DONE;
          else if (pending < SMALL_REST) state_next = ST_FIN_STATUS;
          else state_next = ST_FIN_READ;
        end else state_next = ST_FIN_STATUS;
      end
      ST_FIN_READ:   state_next = ST_FIN_MUL;
      ST_FIN_MUL:    state_next = ST_FIN_DIV;
      ST_FIN_DIV:    state_next = ST_FIN_WAIT2;
      ST_FIN_WAIT2:  if (div_done) state_next = ST_FIN_STATUS;
      ST_FIN_STATUS: state_next = ST_DONE;
      ST_Q_CHECK: begin
        if (qdist[31] || qdist == '0 || qdist >= total || entry_count == '0)
          state_next = ST_DONE;
        else state_next = ST_Q_WAIT;
      end
      ST_Q_WAIT:     if (div_done) state_next = ST_Q_FRAC;
      ST_Q_FRAC:     state_next = ST_Q_FWAIT;
      ST_Q_FWAIT: begin
        if (div_done) state_next = (idx == count_m1) ? ST_DONE : ST_Q_RD0;
      end
      ST_Q_RD0:      state_next = ST_Q_RD1;
      ST_Q_RD1:      state_next = ST_Q_MIX;
      ST_Q_MIX:      state_next = ST_Q_OUT;
      ST_Q_OUT:      state_next = ST_DONE;
      ST_DONE:       if (!out_valid || out_ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = entry_count[AW-1:0];
    mem_wdata    = app_new;
    mem_re       = 1'b0;
    mem_raddr    = idx[AW-1:0];
    div_start    = 1'b0;
    div_dividend = {7'd0, prod};
    div_divisor  = pending;
    sqrt_start   = 1'b0;
    case (state)
      ST_START: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '0;
      end
      ST_DIST_GO: sqrt_start = (sq_sum[65:64] == 2'b00);
      ST_APP_DIV: div_start = 1'b1;
      ST_APP_WAIT: mem_we = div_done;
      ST_FIN_GO: begin
        div_start    = 1'b1;
        div_dividend = {31'd0, 33'({1'b0, total} + {1'b0, res} - 33'd1)};
        div_divisor  = res;
      end
      ST_FIN_DECIDE: begin
        if (!ovf && fq != '0 && 34'(entry_count) == fq && entry_count < DEPTH_C) begin
          if (pending < SMALL_REST) begin
            mem_we    = 1'b1;
            mem_wdata = end_pos[23:0];
          end else begin
            mem_re    = 1'b1;
            mem_raddr = count_m1[AW-1:0];
          end
        end
      end
      ST_FIN_DIV: div_start = 1'b1;
      ST_FIN_WAIT2: begin
        mem_we    = div_done;
        mem_wdata = fin_v;
      end
      ST_Q_CHECK: begin
        div_start    = !(qdist[31] || qdist == '0 || qdist >= total || entry_count == '0);
        div_dividend = {32'd0, qdist};
        div_divisor  = res;
      end
      ST_Q_FRAC: begin
        div_start    = 1'b1;
        div_dividend = {16'd0, div_rem, 16'd0};
        div_divisor  = res;
      end
      ST_Q_RD0: mem_re = 1'b1;
      ST_Q_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(idx + CW'(1));
      end
      default: ;
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      resolution   <= RES_RESET;
      last_segment <= '0;
      entry_count  <= '0;
      pending      <= '0;
      last_pos     <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
      prev_z       <= '0;
      total        <= '0;
      ovf          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        if (cfg_index == REG_RESOLUTION) resolution <= cfg_data;
        else if (cfg_index == REG_LAST_SEGMENT) last_segment <= cfg_data[7:0];
      end

      // result register loads in done once the out port is free
      if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          px       <= point_x;
          py       <= point_y;
          pz       <= point_z;
          next_pos <= curve_position;
          qdist    <= query_distance;
          sq_idx   <= '0;
          sq_sum   <= '0;
          r_seg    <= '0;
          r_blend  <= '0;
          r_status <= STAT_OK;
        end
        ST_START: begin
          entry_count <= CW'(1);
          pending     <= '0;
          last_pos    <= '0;
          total       <= '0;
          ovf         <= 1'b0;
          prev_x      <= px;
          prev_y      <= py;
          prev_z      <= pz;
        end
        ST_DIST_SQ: begin
          sq_sum <= sq_sum + {2'b00, sq_prod};
          sq_idx <= sq_idx + 2'd1;
        end
        ST_DIST_GO: step_len <= 32'hFFFFFFFF;
        ST_DIST_WAIT: if (sqrt_done) step_len <= sqrt_root;
        ST_SAMPLE_ADD: begin
          total   <= tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
          pending <= psum[32] ? 32'hFFFFFFFF : psum[31:0];
        end
        ST_APP_CHECK: begin
          if (!ovf && pending >= res && entry_count >= DEPTH_C) ovf <= 1'b1;
        end
        ST_APP_MUL: begin
          dir_up <= next_pos >= last_pos;
          prod   <= {1'b0, app_prod};
        end
        ST_APP_WAIT: begin
          if (div_done) begin
            last_pos    <= app_new;
            entry_count <= entry_count + CW'(1);
            pending     <= pending - res;
          end
        end
        ST_SAMPLE_END: begin
          prev_x   <= px;
          prev_y   <= py;
          prev_z   <= pz;
          r_status <= ovf ? STAT_OVERFLOW : STAT_OK;
        end
        ST_FIN_WAIT: if (div_done) fq <= div_quot[33:0];
        ST_FIN_DECIDE: begin
          if (ovf) r_status <= STAT_OVERFLOW;
          else if (fq != '0 && 34'(entry_count) == fq) begin
            if (entry_count >= DEPTH_C) begin
              ovf      <= 1'b1;
              r_status <= STAT_OVERFLOW;
            end else if (pending < SMALL_REST) begin
              entry_count <= entry_count + CW'(1);
            end
          end
        end
        ST_FIN_READ: t0 <= mem_rdata;
        ST_FIN_MUL:  prod <= fin_prod;
        ST_FIN_WAIT2: if (div_done) entry_count <= entry_count + CW'(1);
        ST_FIN_STATUS: begin
          r_status <= (34'(entry_count) != fq + 34'd1) ? STAT_MISMATCH : STAT_OK;
        end
        ST_Q_CHECK: begin
          if (!qdist[31] && qdist != '0 && qdist >= total) begin
            r_seg   <= SEGMENT_BITS'(last_segment);
            r_blend <= 17'h10000;
          end
        end
        ST_Q_WAIT: begin
          if (div_done) begin
            idx <= (div_quot > {{(64-CW){1'b0}}, count_m1}) ? count_m1 : div_quot[CW-1:0];
          end
        end
        ST_Q_FWAIT: begin
          if (div_done) begin
            frac <= div_quot[15:0];
            if (idx == count_m1) begin
              r_seg   <= SEGMENT_BITS'(last_segment);
              r_blend <= 17'h10000;
            end
          end
        end
        ST_Q_RD1: t0 <= mem_rdata;
        ST_Q_MIX: begin
          dir_up <= mem_rdata >= t0;
          prod   <= {17'd0, mix_prod};
        end
        ST_Q_OUT: begin
          r_seg   <= SEGMENT_BITS'(q_v >> 16);
          r_blend <= {1'b0, q_v[15:0]};
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            segment      <= r_seg;
            blend        <= r_blend;
            curve_length <= total;
            status       <= r_status;
          end
        end
        default: ;
      endcase
    end
  end

  alm_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  alm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  alm_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sq_sum[63:0]),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

endmodule

// ===== hdl/alm_ram.sv =====
// ----------------------------------------------------------------------------
// alm_ram: position table memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module alm_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/alm_div.sv =====
// ----------------------------------------------------------------------------
// alm_div: iterative divider
// 64 by 32 bit restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic [31:0] remainder
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] num;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] trial;
  logic        take;

  assign trial = {rem, num[63]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse on the last quotient bit
      done <= !start && busy && (cnt == 6'd63);
      if (start) begin
        num  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= take ? 32'(trial - {1'b0, dvs}) : trial[31:0];
        num <= {num[62:0], take};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = num;
  assign remainder = rem;

endmodule

// ===== hdl/alm_sqrt.sv =====
// ----------------------------------------------------------------------------
// alm_sqrt: iterative integer square root
// Digit-by-digit root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module alm_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] val;
  logic [33:0] rem;
  logic [35:0] trial;
  logic [35:0] tgt;
  logic        take;

  assign trial = {rem, val[63:62]};
  assign tgt   = {2'b00, root, 2'b01};
  assign take  = trial >= tgt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse on the last root bit
      done <= !start && busy && (cnt == 5'd31);
      if (start) begin
        val  <= value;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= take ? 34'(trial - tgt) : trial[33:0];
        root <= {root[30:0], take};
        val  <= {val[61:0], 2'b00};
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== bench/tb_arc_length_table_build_and_map_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arc_length_table_build_and_map_core: arc length table self-checking bench
// Directed rows cover reset state, field extremes, the minimum resolution,
// saturated distance, table overflow and the count mismatch at finish. A
// random part then runs builds (start, samples, finish, queries) and noise.
// Results are checked against a predictor of the table logic or typed-in values.
// ----------------------------------------------------------------------------
module tb_arc_length_table_build_and_map_core;
  import alm_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int RANDOM_ITEMS = 450;
  localparam int WATCH_LIMIT = 300000;

  typedef struct packed {
    logic [7:0]  seg;
    logic [16:0] blend;
    logic [31:0] len;
    logic [1:0]  stat;
  } map_result_t;

  typedef struct {
    bit          is_cfg;
    cmd_t        cmd;
    logic [31:0] x, y, z;
    logic [23:0] pos;
    logic [31:0] qd;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    bit          typed;
    map_result_t want;
  } stim_row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] command;
  logic signed [31:0] point_x, point_y, point_z, query_distance;
  logic [23:0] curve_position;
  logic [7:0] segment;
  logic [16:0] blend;
  logic [31:0] curve_length;
  logic [1:0] status;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  arc_length_table_build_and_map_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .curve_position(curve_position), .query_distance(query_distance),
    .out_valid(out_valid), .out_ready(out_ready),
    .segment(segment), .blend(blend), .curve_length(curve_length), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---- predictor state, mirrors the block's registers and table ----
  logic [31:0] p_res, p_last_seg;
  logic [23:0] p_table [DEPTH];
  int unsigned p_count;
  logic [31:0] p_pending, p_total;
  logic [23:0] p_last_pos;
  longint      p_prev [3];
  bit          p_ovf;

  map_result_t expected_q[$];
  int errors = 0;
  int idle_pct = 11;
  int quiet_cycles = 0;
  stim_row_t rows[$];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // integer square root, rounded down
  function automatic logic [31:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // a + (b - a) * num / den, truncated toward a
  function automatic logic [31:0] lerp_pos(logic [31:0] a, logic [31:0] b,
                                           logic [63:0] num, logic [63:0] den);
    logic [63:0] t;
    if (b >= a) begin
      t = ({32'b0, b - a} * num) / den;
      return a + t[31:0];
    end
    t = ({32'b0, a - b} * num) / den;
    return a - t[31:0];
  endfunction

  function automatic logic [31:0] step_length(longint px, longint py, longint pz);
    longint pt [3];
    longint d;
    logic [63:0] m, sum;
    logic [64:0] s;
    pt[0] = px; pt[1] = py; pt[2] = pz;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      d = pt[i] - p_prev[i];
      m = (d < 0) ? -d : d;
      if (m >= 64'h1_0000_0000) return 32'hFFFF_FFFF;
      s = {1'b0, sum} + {1'b0, m * m};
      if (s[64]) return 32'hFFFF_FFFF;
      sum = s[63:0];
    end
    return isqrt(sum);
  endfunction

  function automatic map_result_t predict_item(cmd_t cmd, logic [31:0] x, logic [31:0] y,
                                               logic [31:0] z, logic [23:0] pos,
                                               logic [31:0] qd);
    map_result_t r;
    logic [31:0] res, d, ends, v, t;
    logic [63:0] expn, rem, w, idx, frac, ud;
    longint qd_s;
    res = (p_res < MIN_RES) ? MIN_RES : p_res;
    r = '0;
    case (cmd)
      CMD_START: begin
        p_table[0] = 0;
        p_count = 1;
        p_pending = 0;
        p_last_pos = 0;
        p_total = 0;
        p_ovf = 0;
        p_prev[0] = longint'($signed(x));
        p_prev[1] = longint'($signed(y));
        p_prev[2] = longint'($signed(z));
      end
      CMD_SAMPLE: begin
        d = step_length(longint'($signed(x)), longint'($signed(y)), longint'($signed(z)));
        p_total = add_sat(p_total, d);
        p_pending = add_sat(p_pending, d);
        while (!p_ovf && p_pending >= res) begin
          if (p_count >= DEPTH) begin
            p_ovf = 1;
            break;
          end
          v = lerp_pos({8'b0, p_last_pos}, {8'b0, pos}, res, p_pending);
          p_last_pos = v[23:0];
          p_table[p_count] = p_last_pos;
          p_count++;
          p_pending = p_pending - res;
        end
        p_prev[0] = longint'($signed(x));
        p_prev[1] = longint'($signed(y));
        p_prev[2] = longint'($signed(z));
        r.stat = p_ovf ? STAT_OVERFLOW : STAT_OK;
      end
      CMD_FINISH: begin
        expn = ({32'b0, p_total} + res - 1) / res + 1;
        if (p_ovf) begin
          r.stat = STAT_OVERFLOW;
        end else if (expn >= 2) begin
          if (64'(p_count) + 1 == expn) begin
            ends = (p_last_seg + 1) << 16;
            if (p_count >= DEPTH) begin
              p_ovf = 1;
            end else begin
              if (p_pending < SMALL_REST) begin
                v = ends;
              end else begin
                t = {8'b0, p_table[p_count - 1]};
                rem = (ends > t) ? 64'(ends - t) : 0;
                w = 64'(t) + (rem * res) / p_pending;
                v = (w > 64'hFF_FFFF) ? 32'hFF_FFFF : w[31:0];
              end
              p_table[p_count] = v[23:0];
              p_count++;
            end
          end
          if (p_ovf) r.stat = STAT_OVERFLOW;
          else if (64'(p_count) != expn) r.stat = STAT_MISMATCH;
        end
      end
      default: begin
        qd_s = longint'($signed(qd));
        if (qd_s <= 0) begin
          r.seg = 0;
        end else if (qd_s >= longint'(p_total)) begin
          r.seg = p_last_seg[7:0];
          r.blend = 17'h10000;
        end else if (p_count != 0) begin
          ud = qd_s;
          idx = ud / res;
          frac = ((ud % res) << 16) / res;
          if (idx > p_count - 1) idx = p_count - 1;
          if (idx < p_count - 1 && idx + 1 < DEPTH) begin
            v = lerp_pos({8'b0, p_table[idx]}, {8'b0, p_table[idx + 1]}, frac, 65536);
            r.seg = v[23:16];
            r.blend = {1'b0, v[15:0]};
          end else begin
            r.seg = p_last_seg[7:0];
            r.blend = 17'h10000;
          end
        end
      end
    endcase
    r.len = p_total;
    return r;
  endfunction

  // ---- stimulus ----
  task automatic send_item(cmd_t cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [23:0] pos, logic [31:0] qd,
                           bit typed = 0, map_result_t want = '0);
    map_result_t r;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 0;
      do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    command = cmd;
    point_x = x; point_y = y; point_z = z;
    curve_position = pos;
    query_distance = qd;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    r = predict_item(cmd, x, y, z, pos, qd);
    expected_q.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  // register writes only once every result is back
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    in_valid = 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_write = 1;
    @(negedge clk);
    cfg_write = 0;
    if (idx == REG_RESOLUTION) p_res = val;
    else if (idx == REG_LAST_SEGMENT) p_last_seg = {24'b0, val[7:0]};
  endtask

  task automatic add_row(cmd_t cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                         logic [23:0] pos, logic [31:0] qd,
                         bit typed = 0, map_result_t want = '0);
    stim_row_t s;
    s = '{cmd: CMD_START, default: '0};
    s.cmd = cmd; s.x = x; s.y = y; s.z = z; s.pos = pos; s.qd = qd;
    s.typed = typed; s.want = want;
    rows.push_back(s);
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [31:0] val);
    stim_row_t s;
    s = '{cmd: CMD_START, default: '0};
    s.is_cfg = 1; s.reg_idx = idx; s.reg_val = val;
    rows.push_back(s);
  endtask

  // ---- result checker ----
  always @(posedge clk) begin
    map_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (segment !== e.seg) begin
          $error("segment exp %0d got %0d", e.seg, segment); errors++;
        end
        if (blend !== e.blend) begin
          $error("blend exp %0d got %0d", e.blend, blend); errors++;
        end
        if (curve_length !== e.len) begin
          $error("curve_length exp %0h got %0h", e.len, curve_length); errors++;
        end
        if (status !== e.stat) begin
          $error("status exp %0d got %0d", e.stat, status); errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // watchdog: cycles in which neither channel moves an item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCH_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // ---- main sequence ----
  initial begin
    int sent;
    int nsamp, nq;
    logic [31:0] step, bx, by, bz, qd;
    logic [23:0] cur;
    map_result_t w;

    rst = 1;
    in_valid = 0; command = CMD_START;
    point_x = 0; point_y = 0; point_z = 0; curve_position = 0; query_distance = 0;
    cfg_write = 0; cfg_index = REG_RESOLUTION; cfg_data = 0;
    p_res = RES_RESET; p_last_seg = 0;
    p_count = 0; p_pending = 0; p_total = 0; p_last_pos = 0; p_ovf = 0;
    p_prev[0] = 0; p_prev[1] = 0; p_prev[2] = 0;
    for (int i = 0; i < DEPTH; i++) p_table[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed rows; values straight after reset are typed in
    w = '{seg: 8'd0, blend: 17'h10000, len: 32'd0, stat: STAT_OK};
    add_row(CMD_QUERY, 0, 0, 0, 0, 100, 1, w);
    w.blend = 0;
    add_row(CMD_QUERY, 0, 0, 0, 0, -5, 1, w);
    w.blend = 17'h10000;
    add_row(CMD_QUERY, 0, 0, 0, 0, 32'h7FFF_FFFF, 1, w);
    w.blend = 0;
    add_row(CMD_FINISH, 0, 0, 0, 0, 0, 1, w);        // one entry expected: nothing written
    add_row(CMD_START, 0, 0, 0, 0, 0, 1, w);
    add_row(CMD_SAMPLE, 19662, 0, 0, 24'h010000, 0);
    add_row(CMD_SAMPLE, 19662, 6554, -6554, 24'h018000, 0);
    add_row(CMD_SAMPLE, 19662, 6554, -6554, 24'h020000, 0);  // zero step
    add_row(CMD_FINISH, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 1);
    add_row(CMD_QUERY, 0, 0, 0, 0, 10000);
    add_row(CMD_QUERY, 0, 0, 0, 0, 0);
    // extreme coordinates: step length saturates
    add_cfg(REG_LAST_SEGMENT, 255);
    add_cfg(REG_RESOLUTION, 32'hFFFF_FFFF);
    add_row(CMD_START, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
    add_row(CMD_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 0);
    add_row(CMD_FINISH, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 32'h7FFF_FFFF);
    add_row(CMD_QUERY, 0, 0, 0, 0, 32'h8000_0000);
    // resolution below the floor runs at the minimum step
    add_cfg(REG_RESOLUTION, 0);
    add_row(CMD_START, 0, 0, 0, 0, 0);
    add_row(CMD_SAMPLE, 10000, 0, 0, 24'h010000, 0);
    add_row(CMD_FINISH, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 5000);
    // resolution changed mid-build: count mismatch at finish
    add_cfg(REG_RESOLUTION, RES_RESET);
    add_cfg(REG_LAST_SEGMENT, 3);
    add_row(CMD_START, 0, 0, 0, 0, 0);
    add_row(CMD_SAMPLE, 13108, 0, 0, 24'h020000, 0);
    add_cfg(REG_RESOLUTION, MIN_RES);
    add_row(CMD_FINISH, 0, 0, 0, 0, 0);
    // table overflow, then sample and finish with the flag set
    add_row(CMD_START, 0, 0, 0, 0, 0);
    add_row(CMD_SAMPLE, 70000, 0, 0, 24'h040000, 0);
    add_row(CMD_SAMPLE, 70001, 0, 0, 24'h040000, 0);
    add_row(CMD_FINISH, 0, 0, 0, 0, 0);
    add_row(CMD_QUERY, 0, 0, 0, 0, 3000);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].reg_idx, rows[i].reg_val);
      else send_item(rows[i].cmd, rows[i].x, rows[i].y, rows[i].z, rows[i].pos,
                     rows[i].qd, rows[i].typed, rows[i].want);
    end
    write_reg(REG_RESOLUTION, RES_RESET);

    // random part: mostly well-formed builds, some noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_pct = (sent > 150 && sent < 260) ? 0 : 11;   // one stretch with no gaps
      if ($urandom_range(0, 99) < 80) begin
        if (p_res > 32'h0002_0000 || $urandom_range(0, 99) < 30) begin
          case ($urandom_range(0, 3))
            0: step = MIN_RES;
            1: step = RES_RESET;
            2: step = 32'h0001_0000;
            default: step = $urandom_range(66, 20000);
          endcase
          write_reg(REG_RESOLUTION, step);
          case ($urandom_range(0, 2))
            0: write_reg(REG_LAST_SEGMENT, 0);
            1: write_reg(REG_LAST_SEGMENT, 255);
            default: write_reg(REG_LAST_SEGMENT, $urandom_range(0, 255));
          endcase
        end
        step = (p_res < MIN_RES) ? MIN_RES : p_res;
        bx = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
        by = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
        bz = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
        cur = 0;
        send_item(CMD_START, bx, by, bz, 0, 0);
        nsamp = $urandom_range(2, 8);
        for (int k = 0; k < nsamp; k++) begin
          bx = bx + $urandom_range(0, 2 * step) - step;
          by = by + $urandom_range(0, 2 * step) - step;
          bz = bz + $urandom_range(0, 2 * step) - step;
          if ($urandom_range(0, 9) == 0) cur = $urandom;
          else if (cur < 24'hFD_0000) cur = cur + $urandom_range(0, 24'h020000);
          send_item(CMD_SAMPLE, bx, by, bz, cur, 0);
        end
        sent += nsamp + 1;
        if ($urandom_range(0, 99) < 10)
          write_reg(REG_RESOLUTION, step + $urandom_range(0, 200) - 100);
        send_item(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom);
        nq = $urandom_range(2, 6);
        for (int k = 0; k < nq; k++) begin
          case ($urandom_range(0, 7))
            0: qd = -$urandom_range(1, 32'h7FFF_FFFF);
            1: qd = 0;
            2: qd = p_total;
            3: qd = p_total + $urandom_range(1, 1000);
            4: qd = 32'h7FFF_FFFF;
            default: qd = $urandom_range(1, (p_total > 1) ? p_total - 1 : 1);
          endcase
          send_item(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, qd);
        end
        sent += nq + 1;
      end else begin
        // noise: coarse step keeps the append loop short
        write_reg(REG_RESOLUTION, $urandom_range(32'h1000_0000, 32'hFFFF_FFFF));
        for (int k = 0; k < 6; k++)
          send_item(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        sent += 6;
      end
    end
    in_valid = 0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
